// ===== design/lfr_pkg.sv =====
package lfr_pkg;

    // datapath widths
    localparam int IN_W   = 24;
    localparam int OUT_W  = 32;
    localparam int CW     = 62;    // cordic word, q60 plus guard and sign
    localparam int Q30_W  = 32;    // signed q30 value in [-1, 1]
    localparam int MAXSTEPS = 60;

    // converged inverse cordic gain, q60
    localparam logic signed [CW-1:0] INV_GAIN_Q60 = 62'sh9B74EDA8 <<< 28;
    localparam logic signed [Q30_W-1:0] ONE30 = 32'sd1073741824;

    typedef logic signed [CW-1:0]    t_cw;
    typedef logic signed [Q30_W-1:0] t_q30;

    // round half up q60 to q30 and clamp to [-1, 1]
    function automatic t_q30 q60_to_q30(input t_cw v);
        logic signed [CW:0] t;
        logic signed [CW:0] r;
        begin
            t = {v[CW-1], v} + (63'sd1 <<< 29);
            r = t >>> 30;
            if (r > 63'sd1073741824) q60_to_q30 = ONE30;
            else if (r < -63'sd1073741824) q60_to_q30 = -ONE30;
            else q60_to_q30 = r[Q30_W-1:0];
        end
    endfunction

    // rounded q30 product
    function automatic t_q30 mul30(input t_q30 a, input t_q30 b);
        logic signed [63:0] p;
        begin
            p = 64'(a) * 64'(b) + (64'sd1 <<< 29);
            mul30 = 32'(p >>> 30);
        end
    endfunction

endpackage

// ===== design/lfr_cordic_cell.sv =====
module lfr_cordic_cell
    import lfr_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic i_clk,
    input  logic i_vec_x_valid,
    input  t_cw  i_x,
    input  t_cw  i_y,
    input  t_cw  i_u,
    input  t_cw  i_v,
    output t_cw  o_x,
    output t_cw  o_y,
    output t_cw  o_u,
    output t_cw  o_v
);
    logic d;

    // vectoring decision replayed on the rotation pair in the same cell
    assign d = ~i_y[CW-1];

    always_ff @(posedge i_clk) begin
        if (i_vec_x_valid) begin
            if (d) begin
                o_x <= i_x + (i_y >>> STEP);
                o_y <= i_y - (i_x >>> STEP);
                o_u <= i_u - (i_v >>> STEP);
                o_v <= i_v + (i_u >>> STEP);
            end else begin
                o_x <= i_x - (i_y >>> STEP);
                o_y <= i_y + (i_x >>> STEP);
                o_u <= i_u + (i_v >>> STEP);
                o_v <= i_v - (i_u >>> STEP);
            end
        end
    end
endmodule

// ===== design/lfr_unit_dir.sv =====
module lfr_unit_dir
    import lfr_pkg::*;
#(
    parameter int STEPS = 32,
    parameter int XW    = 62
) (
    input  logic                 i_clk,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    output t_q30                 o_c,
    output t_q30                 o_s
);
    localparam int NS = (STEPS > MAXSTEPS) ? MAXSTEPS : ((STEPS < 1) ? 1 : STEPS);
    localparam int SHW = $clog2(XW + 60);

    // stage 0: leading bit position of the larger magnitude
    logic signed [XW-1:0] r_x0, r_y0;
    logic [XW-1:0] ax, ay, am;
    logic [SHW-1:0] lead;
    logic r_zero0;

    always_comb begin
        ax = i_x[XW-1] ? XW'(-i_x) : XW'(i_x);
        ay = i_y[XW-1] ? XW'(-i_y) : XW'(i_y);
        am = (ax > ay) ? ax : ay;
        lead = '0;
        for (int k = 0; k < XW; k++) if (am[k]) lead = SHW'(k);
    end

    logic [SHW-1:0] r_lead0;
    always_ff @(posedge i_clk) begin
        r_x0 <= i_x;
        r_y0 <= i_y;
        r_lead0 <= lead;
        r_zero0 <= (i_x == '0) && (i_y == '0);
    end

    // stage 1: normalize into [2^57, 2^58) then turn a negative x by pi
    localparam int WW = XW + 60;
    localparam logic signed [WW-1:0] NEG58 = -(WW'(1) <<< 58);
    logic signed [WW-1:0] wx, wy;
    t_cw nx, ny;
    logic neg;
    always_comb begin
        wx = WW'(r_x0);
        wy = WW'(r_y0);
        if (r_lead0 >= SHW'(57)) begin
            wx = wx >>> (r_lead0 - SHW'(57));
            wy = wy >>> (r_lead0 - SHW'(57));
            // a negative value can round down onto -2^58, one more halving
            if (wx == NEG58 || wy == NEG58) begin
                wx = wx >>> 1;
                wy = wy >>> 1;
            end
        end else begin
            wx = wx <<< (SHW'(57) - r_lead0);
            wy = wy <<< (SHW'(57) - r_lead0);
        end
        neg = wx[WW-1];
        nx = neg ? CW'(-wx) : CW'(wx);
        ny = neg ? CW'(-wy) : CW'(wy);
    end

    t_cw x_c [0:NS];
    t_cw y_c [0:NS];
    t_cw u_c [0:NS];
    t_cw v_c [0:NS];
    logic r_zero [0:NS];

    always_ff @(posedge i_clk) begin
        x_c[0] <= nx;
        y_c[0] <= ny;
        u_c[0] <= neg ? -INV_GAIN_Q60 : INV_GAIN_Q60;
        v_c[0] <= '0;
        r_zero[0] <= r_zero0;
    end

    // row of micro-rotation cells
    for (genvar g = 0; g < NS; g++) begin : g_cell
        lfr_cordic_cell #(.STEP(g)) u_cell (
            .i_clk        (i_clk),
            .i_vec_x_valid(1'b1),
            .i_x(x_c[g]), .i_y(y_c[g]), .i_u(u_c[g]), .i_v(v_c[g]),
            .o_x(x_c[g+1]), .o_y(y_c[g+1]), .o_u(u_c[g+1]), .o_v(v_c[g+1])
        );
        always_ff @(posedge i_clk) r_zero[g+1] <= r_zero[g];
    end

    // final rounding to q30
    always_ff @(posedge i_clk) begin
        if (r_zero[NS]) begin
            o_c <= ONE30;
            o_s <= '0;
        end else begin
            o_c <= q60_to_q30(u_c[NS]);
            o_s <= q60_to_q30(v_c[NS]);
        end
    end
endmodule

// ===== design/lepton_frame_rotation.sv =====
// lepton frame rotation
// request channel: drive i_jet_*, i_lep_* and i_lep_momentum with start high;
// busy is always low, so a request is taken on every edge where start is
// high, one per cycle.
// result channel: o_valid pulses for one cycle with o_m00..o_m22 (rotation
// matrix entries, q2.30 scaled to min(FRAC_BITS, 30) fraction bits) and o_invalid (zero magnitude).
// path of a request: the ratio divider and square root cell rows, with the
// phi cordic row running beside them, then the alignment delay lines, jet
// rotation stages a and b, the alpha cordic row, the two matrix stages and
// output rounding; each cordic row has CORDIC_STEPS cells (limited to 1..60).
// throughput one request per cycle.
// results come out in request order; the receiver cannot stall, each result
// is shown for exactly one cycle.
// reset (synchronous, active low) clears the valid pipeline only; data in
// flight is dropped.
module lepton_frame_rotation
    import lfr_pkg::*;
#(
    parameter int FRAC_BITS    = 30,
    parameter int CORDIC_STEPS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [IN_W-1:0]  i_jet_px,
    input  logic signed [IN_W-1:0]  i_jet_py,
    input  logic signed [IN_W-1:0]  i_jet_pz,
    input  logic signed [IN_W-1:0]  i_lep_px,
    input  logic signed [IN_W-1:0]  i_lep_py,
    input  logic signed [IN_W-1:0]  i_lep_pz,
    input  logic        [IN_W-1:0]  i_lep_momentum,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_m00,
    output logic signed [OUT_W-1:0] o_m01,
    output logic signed [OUT_W-1:0] o_m02,
    output logic signed [OUT_W-1:0] o_m10,
    output logic signed [OUT_W-1:0] o_m11,
    output logic signed [OUT_W-1:0] o_m12,
    output logic signed [OUT_W-1:0] o_m20,
    output logic signed [OUT_W-1:0] o_m21,
    output logic signed [OUT_W-1:0] o_m22,
    output logic                    o_invalid
);
    localparam int NS = (CORDIC_STEPS > MAXSTEPS) ? MAXSTEPS
                      : ((CORDIC_STEPS < 1) ? 1 : CORDIC_STEPS);
    localparam int LU  = NS + 3;      // unit_dir latency
    localparam int DIVN = 31;         // quotient bits of r
    localparam int SQN  = 31;         // result bits of sqrt
    localparam int DSQ  = DIVN + SQN + 3;   // cycles until cy and sy are registered
    localparam int L1  = (DSQ > LU) ? DSQ : LU;
    localparam int LAT = L1 + LU + 6;
    localparam int OSH = (FRAC_BITS >= 30) ? 0 : 30 - FRAC_BITS;

    assign busy = 1'b0;

    // valid pipe
    logic [LAT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else          r_vld <= {r_vld[LAT-2:0], start};
    end
    assign o_valid = r_vld[LAT-1];

    // phi direction from the lepton transverse momentum
    t_q30 cz_u, s_u;
    lfr_unit_dir #(.STEPS(NS), .XW(IN_W)) u_phi (
        .i_clk(i_clk), .i_x(i_lep_px), .i_y(i_lep_py), .o_c(cz_u), .o_s(s_u)
    );

    // ratio |lz|/p: restoring divider, one quotient bit per cell
    logic [IN_W+DIVN-1:0] r_rem [0:DIVN];
    logic [IN_W-1:0]      r_p   [0:DIVN];
    logic [DIVN-1:0]      r_q   [0:DIVN];
    logic                 r_sat [0:DIVN];
    logic                 r_ng  [0:DIVN];
    logic [IN_W-1:0] alz;
    assign alz = i_lep_pz[IN_W-1] ? IN_W'(-i_lep_pz) : IN_W'(i_lep_pz);

    always_ff @(posedge i_clk) begin
        r_rem[0] <= (IN_W+DIVN)'(alz);
        r_p[0]   <= i_lep_momentum;
        r_q[0]   <= '0;
        r_sat[0] <= alz >= i_lep_momentum;
        r_ng[0]  <= i_lep_pz[IN_W-1];
    end

    for (genvar g = 0; g < DIVN; g++) begin : g_div
        logic [IN_W+DIVN-1:0] sh;
        logic [IN_W+DIVN-1:0] dv;
        assign sh = (g == 0) ? (r_rem[g] << 30) : r_rem[g];
        assign dv = (IN_W+DIVN)'(r_p[g]) << (30 - g);
        always_ff @(posedge i_clk) begin
            r_p[g+1]   <= r_p[g];
            r_sat[g+1] <= r_sat[g];
            r_ng[g+1]  <= r_ng[g];
            if (sh >= dv) begin
                r_rem[g+1] <= sh - dv;
                r_q[g+1]   <= r_q[g] | (DIVN'(1) << (30 - g));
            end else begin
                r_rem[g+1] <= sh;
                r_q[g+1]   <= r_q[g];
            end
        end
    end

    // signed r and 1 - r^2
    t_q30 sy_d;
    logic [61:0] r_rad;
    t_q30 r_sy;
    always_comb begin
        sy_d = r_sat[DIVN] ? ONE30 : t_q30'({1'b0, r_q[DIVN]});
        if (r_ng[DIVN]) sy_d = -sy_d;
    end
    always_ff @(posedge i_clk) begin
        r_sy  <= sy_d;
        r_rad <= 62'((64'd1 << 60) - (64'(sy_d) * 64'(sy_d)));
    end

    // square root, one result bit per cell
    logic [61:0] r_n  [0:SQN];
    logic [61:0] r_rs [0:SQN];
    t_q30        r_sq [0:SQN];
    always_ff @(posedge i_clk) begin
        r_n[0]  <= r_rad;
        r_rs[0] <= '0;
        r_sq[0] <= r_sy;
    end
    for (genvar g = 0; g < SQN; g++) begin : g_sqrt
        localparam logic [61:0] BIT = 62'd1 << (60 - 2*g);
        always_ff @(posedge i_clk) begin
            r_sq[g+1] <= r_sq[g];
            if (r_n[g] >= r_rs[g] + BIT) begin
                r_n[g+1]  <= r_n[g] - (r_rs[g] + BIT);
                r_rs[g+1] <= (r_rs[g] >> 1) + BIT;
            end else begin
                r_n[g+1]  <= r_n[g];
                r_rs[g+1] <= r_rs[g] >> 1;
            end
        end
    end

    // align all first-stage product operands to L1
    localparam int PAD_S = L1 - DSQ;
    localparam int PAD_U = L1 - LU;
    t_q30 cy_a, sy_a, cz_a, sz_a;
    logic signed [IN_W-1:0] jx_a, jy_a, jz_a;
    logic                   inv_a;

    // delay lines (shift registers)
    logic signed [IN_W-1:0] r_jx [0:L1];
    logic signed [IN_W-1:0] r_jy [0:L1];
    logic signed [IN_W-1:0] r_jz [0:L1];
    logic                   r_iv [0:L1];
    always_ff @(posedge i_clk) begin
        r_jx[0] <= i_jet_px;
        r_jy[0] <= i_jet_py;
        r_jz[0] <= i_jet_pz;
        r_iv[0] <= i_lep_momentum == '0;
        for (int k = 1; k <= L1; k++) begin
            r_jx[k] <= r_jx[k-1];
            r_jy[k] <= r_jy[k-1];
            r_jz[k] <= r_jz[k-1];
            r_iv[k] <= r_iv[k-1];
        end
    end
    t_q30 r_cz [0:PAD_U];
    t_q30 r_sz [0:PAD_U];
    t_q30 r_cy [0:PAD_S];
    t_q30 r_syd[0:PAD_S];
    always_ff @(posedge i_clk) begin
        r_cz[0] <= cz_u;
        r_sz[0] <= -s_u;
        r_cy[0] <= t_q30'(r_rs[SQN]);
        r_syd[0] <= r_sq[SQN];
        for (int k = 1; k <= PAD_U; k++) begin
            r_cz[k] <= r_cz[k-1];
            r_sz[k] <= r_sz[k-1];
        end
        for (int k = 1; k <= PAD_S; k++) begin
            r_cy[k] <= r_cy[k-1];
            r_syd[k] <= r_syd[k-1];
        end
    end
    assign cz_a = r_cz[PAD_U];
    assign sz_a = r_sz[PAD_U];
    assign cy_a = r_cy[PAD_S];
    assign sy_a = r_syd[PAD_S];
    assign jx_a = r_jx[L1];
    assign jy_a = r_jy[L1];
    assign jz_a = r_jz[L1];
    assign inv_a = r_iv[L1];

    // jet rotation, stage a: products
    logic signed [63:0] r_cx, r_sjy, r_sjx, r_cjy, r_czjz;
    t_q30 r_cz1, r_sz1, r_cy1, r_sy1;
    logic r_iv1;
    always_ff @(posedge i_clk) begin
        r_cx   <= 64'(cz_a) * 64'(jx_a);
        r_sjy  <= 64'(sz_a) * 64'(jy_a);
        r_sjx  <= 64'(sz_a) * 64'(jx_a);
        r_cjy  <= 64'(cz_a) * 64'(jy_a);
        r_czjz <= 64'(cy_a) * 64'(jz_a);
        r_cz1 <= cz_a; r_sz1 <= sz_a; r_cy1 <= cy_a; r_sy1 <= sy_a;
        r_iv1 <= inv_a;
    end
    // stage b: b1, b2
    logic signed [63:0] a0, a0r, b1, b2;
    always_comb begin
        a0  = r_cx - r_sjy;
        a0r = (a0 + (64'sd1 <<< 21)) >>> 22;
        b1  = (r_sjx + r_cjy) <<< 8;
        b2  = (r_czjz <<< 8) - 64'(r_sy1) * a0r;
    end
    logic signed [63:0] r_b1, r_b2;
    always_ff @(posedge i_clk) begin
        r_b1 <= b1;
        r_b2 <= b2;
    end

    // alpha direction
    t_q30 ca_u, sa_u;
    lfr_unit_dir #(.STEPS(NS), .XW(64)) u_alpha (
        .i_clk(i_clk), .i_x(r_b1), .i_y(r_b2), .o_c(ca_u), .o_s(sa_u)
    );

    t_q30 r_dcz [0:LU];
    t_q30 r_dsz [0:LU];
    t_q30 r_dcy [0:LU];
    t_q30 r_dsy [0:LU];
    logic r_div [0:LU];
    always_ff @(posedge i_clk) begin
        r_dcz[0] <= r_cz1; r_dsz[0] <= r_sz1; r_dcy[0] <= r_cy1; r_dsy[0] <= r_sy1;
        r_div[0] <= r_iv1;
        for (int k = 1; k <= LU; k++) begin
            r_dcz[k] <= r_dcz[k-1]; r_dsz[k] <= r_dsz[k-1];
            r_dcy[k] <= r_dcy[k-1]; r_dsy[k] <= r_dsy[k-1];
            r_div[k] <= r_div[k-1];
        end
    end

    // matrix stage 1: two-factor products
    t_q30 ca, sa, cz, sz, cy, sy;
    assign ca = ca_u; assign sa = -sa_u;
    assign cz = r_dcz[LU]; assign sz = r_dsz[LU];
    assign cy = r_dcy[LU]; assign sy = r_dsy[LU];
    t_q30 r_t, r_u, r_ca, r_sa, r_cz2, r_sz2, r_cy2, r_sy2;
    logic r_iv2;
    always_ff @(posedge i_clk) begin
        r_t <= mul30(cz, sy); r_u <= mul30(sz, sy);
        r_ca <= ca; r_sa <= sa; r_cz2 <= cz; r_sz2 <= sz; r_cy2 <= cy; r_sy2 <= sy;
        r_iv2 <= r_div[LU];
    end
    // stage 2: entries
    logic signed [33:0] r_m [0:8];
    logic r_iv3;
    always_ff @(posedge i_clk) begin
        r_m[0] <= 34'(mul30(r_cz2, r_cy2));
        r_m[1] <= 34'(mul30(r_t, r_sa)) + 34'(mul30(r_sz2, r_ca));
        r_m[2] <= 34'(mul30(r_sz2, r_sa)) - 34'(mul30(r_t, r_ca));
        r_m[3] <= -34'(mul30(r_sz2, r_cy2));
        r_m[4] <= 34'(mul30(r_cz2, r_ca)) - 34'(mul30(r_u, r_sa));
        r_m[5] <= 34'(mul30(r_u, r_ca)) + 34'(mul30(r_cz2, r_sa));
        r_m[6] <= 34'(r_sy2);
        r_m[7] <= -34'(mul30(r_cy2, r_sa));
        r_m[8] <= 34'(mul30(r_cy2, r_ca));
        r_iv3 <= r_iv2;
    end

    // output rounding and clamp
    function automatic logic signed [OUT_W-1:0] oent(input logic signed [33:0] v);
        logic signed [33:0] c, r;
        begin
            c = (v > 34'sd1073741824) ? 34'sd1073741824 :
                ((v < -34'sd1073741824) ? -34'sd1073741824 : v);
            r = (c + ((34'sd1 <<< OSH) >>> 1)) >>> OSH;
            if (r > (34'sd1073741824 >>> OSH)) r = 34'sd1073741824 >>> OSH;
            if (r < -(34'sd1073741824 >>> OSH)) r = -(34'sd1073741824 >>> OSH);
            oent = r[OUT_W-1:0];
        end
    endfunction

    logic signed [OUT_W-1:0] r_o [0:8];
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 9; k++) r_o[k] <= r_iv3 ? '0 : oent(r_m[k]);
        o_invalid <= r_iv3;
    end
    assign o_m00 = r_o[0]; assign o_m01 = r_o[1]; assign o_m02 = r_o[2];
    assign o_m10 = r_o[3]; assign o_m11 = r_o[4]; assign o_m12 = r_o[5];
    assign o_m20 = r_o[6]; assign o_m21 = r_o[7]; assign o_m22 = r_o[8];
endmodule
